/* src/utf8v_pkg.sv */
`default_nettype none
package utf8v_pkg;

  localparam int unsigned UTF8V_QUEUE_DEPTH = 4;

  // byte masks and patterns
  localparam logic [7:0] MASK_HI   = 8'h80;
  localparam logic [7:0] MASK_CONT = 8'hC0;
  localparam logic [7:0] PAT_CONT  = 8'h80;
  localparam logic [7:0] MASK_L2   = 8'hE0;
  localparam logic [7:0] PAT_L2    = 8'hC0;
  localparam logic [7:0] MASK_L3   = 8'hF0;
  localparam logic [7:0] PAT_L3    = 8'hE0;
  localparam logic [7:0] MASK_L4   = 8'hF8;
  localparam logic [7:0] PAT_L4    = 8'hF0;
  localparam logic [7:0] MIN_AFTER_E0 = 8'hA0;
  localparam logic [7:0] MIN_AFTER_F0 = 8'h90;

  // bound on the first continuation byte
  localparam logic [1:0] BOUND_NONE = 2'd0;
  localparam logic [1:0] BOUND_A0   = 2'd1;
  localparam logic [1:0] BOUND_90   = 2'd2;

  // classified item, as held in the queue
  typedef struct packed {
    logic       has_byte;
    logic       end_of_string;
    logic       is_cont;
    logic       below_a0;
    logic       below_90;
    logic       lead_bad;
    logic [1:0] lead_len;
    logic [1:0] lead_bound;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic [1:0] pend;
    logic [1:0] bound;
    logic       err;
  } bstat_t;

endpackage
`default_nettype wire

/* src/utf8_stream_validator_unit.sv */
`default_nettype none
// UTF-8 stream validator: one byte (or bare end marker) per item, one verdict per string.
// The end-of-string item is written to the queue, then checked by the back end, which
// registers the verdict; out_valid stays high until out_ready takes it.
// Throughput: 1 item per cycle sustained, held off only while the item queue is full.
// in_ready drops only when the item queue is full (result stalled by out_ready).
// Reset (rst_n low, synchronous): queue emptied, decoder state and out_valid cleared.
module utf8_stream_validator_unit #(
  parameter int unsigned QUEUE_DEPTH = utf8v_pkg::UTF8V_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_has_byte,
  input  wire logic       in_end_of_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_is_valid
);
  import utf8v_pkg::*;

  item_t  front_item;   // classified incoming item
  item_t  head_item;    // oldest queued item
  qstat_t q_stat;
  bstat_t b_stat;
  logic   pop;

  // front: byte classification, no state
  utf8v_front u_front (
    .in_data_byte     (in_data_byte),
    .in_has_byte      (in_has_byte),
    .in_end_of_string (in_end_of_string),
    .item             (front_item)
  );

  // short queue decouples input from a stalled result
  utf8v_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  assign in_ready = !q_stat.full;

  // back: sequence tracking and the registered verdict
  utf8v_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (!q_stat.empty),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_valid (out_is_valid),
    .stat         (b_stat)
  );

  // queue can't be both empty and full
  a_q_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.empty && q_stat.full))
    else $error("queue empty and full at once");

  // an accepted item is visible to the back end next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !q_stat.empty)
    else $error("accepted item lost by queue");

  // a first-byte bound only exists while two or more continuations are due
  a_bound_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (b_stat.bound != BOUND_NONE) |-> (b_stat.pend == 2'd2 || b_stat.pend == 2'd3))
    else $error("bound without pending continuations");

  // no pop of a string end while the result slot stays blocked
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !(pop && head_item.end_of_string))
    else $error("verdict overwritten while stalled");

endmodule
`default_nettype wire

/* src/utf8v_front.sv */
`default_nettype none
module utf8v_front (
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_has_byte,
  input  wire logic             in_end_of_string,
  output utf8v_pkg::item_t      item
);
  import utf8v_pkg::*;

  logic [7:0] b;

  assign b = in_data_byte;

  always_comb begin
    item = '0;
    item.has_byte      = in_has_byte;
    item.end_of_string = in_end_of_string;
    item.is_cont       = ((b & MASK_CONT) == PAT_CONT);
    item.below_a0      = (b < MIN_AFTER_E0);
    item.below_90      = (b < MIN_AFTER_F0);
    priority if ((b & MASK_HI) == 8'h00) begin
      item.lead_len = 2'd0;
    end else if ((b & MASK_L2) == PAT_L2) begin
      item.lead_len = 2'd1;
    end else if ((b & MASK_L3) == PAT_L3) begin
      item.lead_len   = 2'd2;
      item.lead_bound = (b == PAT_L3) ? BOUND_A0 : BOUND_NONE;
    end else if ((b & MASK_L4) == PAT_L4) begin
      item.lead_len   = 2'd3;
      item.lead_bound = (b == PAT_L4) ? BOUND_90 : BOUND_NONE;
    end else begin
      item.lead_bad = 1'b1;
    end
  end

endmodule
`default_nettype wire

/* src/utf8v_queue.sv */
`default_nettype none
module utf8v_queue #(
  parameter int unsigned DEPTH = utf8v_pkg::UTF8V_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire utf8v_pkg::item_t push_item,
  input  wire logic             pop,
  output utf8v_pkg::item_t      head_item,
  output utf8v_pkg::qstat_t     stat
);
  import utf8v_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == FULL_CNT);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* src/utf8v_back.sv */
`default_nettype none
module utf8v_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  wire utf8v_pkg::item_t head_item,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_is_valid,
  output utf8v_pkg::bstat_t     stat
);
  import utf8v_pkg::*;

  logic [1:0] pend_r, pend_nxt;
  logic [1:0] bound_r, bound_nxt;
  logic       err_r, err_nxt;
  logic       ov_r, ov_nxt;
  logic       res_r, res_nxt;
  logic       bad_cont;

  // a result item needs a free output slot
  assign pop = head_valid && (!head_item.end_of_string || !ov_r || out_ready);

  assign bad_cont = !head_item.is_cont
                 || (bound_r == BOUND_A0 && head_item.below_a0)
                 || (bound_r == BOUND_90 && head_item.below_90);

  always_comb begin
    pend_nxt  = pend_r;
    bound_nxt = bound_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r && !out_ready;
    res_nxt   = res_r;
    if (pop) begin
      if (head_item.has_byte && !err_r) begin
        if (pend_r != 2'd0) begin
          err_nxt   = bad_cont;
          bound_nxt = BOUND_NONE;
          pend_nxt  = pend_r - 2'd1;
        end else if (head_item.lead_bad) begin
          err_nxt = 1'b1;
        end else begin
          pend_nxt  = head_item.lead_len;
          bound_nxt = head_item.lead_bound;
        end
      end
      if (head_item.end_of_string) begin
        ov_nxt    = 1'b1;
        res_nxt   = !err_nxt && (pend_nxt == 2'd0);
        pend_nxt  = 2'd0;
        bound_nxt = BOUND_NONE;
        err_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 2'd0;
      bound_r <= BOUND_NONE;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      bound_r <= bound_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid    = ov_r;
  assign out_is_valid = res_r;
  assign stat.pend    = pend_r;
  assign stat.bound   = bound_r;
  assign stat.err     = err_r;

endmodule
`default_nettype wire

/* tb/utf8_stream_validator_unit_tb.sv */
`default_nettype none
module utf8_stream_validator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8v_pkg::*;

  // ---------------------------------------------------------------------------
  // DUT connections: every input starts at a known value
  // ---------------------------------------------------------------------------
  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic [7:0] in_data_byte     = 8'h00;
  logic       in_has_byte      = 1'b0;
  logic       in_end_of_string = 1'b0;
  logic       out_ready        = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_is_valid;

  utf8_stream_validator_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_has_byte      (in_has_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_valid     (out_is_valid)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop. Slowest legit run is roughly 700 items, with sender gaps between
  // bursts and string verdicts held off by receiver stalls; that is well under
  // 160 us. 2 ms leaves ample margin.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow: mirrors the per-string UTF-8 state and predicts verdicts
  // ---------------------------------------------------------------------------
  logic [1:0] dec_pend  = 2'd0;       // continuation bytes still owed
  logic [1:0] dec_bound = BOUND_NONE; // extra floor on the next continuation
  logic       dec_err   = 1'b0;       // string already failed

  logic       expected_verdicts[$];   // one entry per end marker, oldest first

  int unsigned n_errors      = 0;
  int unsigned n_strings     = 0;
  int unsigned n_good        = 0;
  int unsigned n_byte_items  = 0;
  int unsigned n_idle_items  = 0;
  int unsigned n_checked     = 0;

  // Called once per accepted item, in acceptance order.
  task automatic predict_utf8_item(input logic [7:0] b, input logic has, input logic eos);
    logic verdict;
    if (has && !dec_err) begin
      if (dec_pend != 2'd0) begin
        // expecting 10xxxxxx, possibly with a raised floor after E0 / F0
        if ((b & MASK_CONT) != PAT_CONT) dec_err = 1'b1;
        else if (dec_bound == BOUND_A0 && b < MIN_AFTER_E0) dec_err = 1'b1;
        else if (dec_bound == BOUND_90 && b < MIN_AFTER_F0) dec_err = 1'b1;
        dec_bound = BOUND_NONE;
        dec_pend  = dec_pend - 2'd1;
      end else if ((b & MASK_HI) == 8'h00) begin
        // plain ASCII, nothing to track
      end else if ((b & MASK_L2) == PAT_L2) begin
        dec_pend  = 2'd1;
        dec_bound = BOUND_NONE;
      end else if ((b & MASK_L3) == PAT_L3) begin
        dec_pend  = 2'd2;
        dec_bound = (b == PAT_L3) ? BOUND_A0 : BOUND_NONE;
      end else if ((b & MASK_L4) == PAT_L4) begin
        dec_pend  = 2'd3;
        dec_bound = (b == PAT_L4) ? BOUND_90 : BOUND_NONE;
      end else begin
        // stray continuation or F8-FF where a lead belongs
        dec_err = 1'b1;
      end
    end
    if (has || eos) n_byte_items++;
    else n_idle_items++;
    if (eos) begin
      verdict = !dec_err && (dec_pend == 2'd0);
      expected_verdicts = {expected_verdicts, verdict};
      n_strings++;
      if (verdict) n_good++;
      dec_pend  = 2'd0;
      dec_bound = BOUND_NONE;
      dec_err   = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // Entered after a rising edge; returns past the taking edge with in_ready high.
  task automatic send_item(input logic [7:0] b, input logic has, input logic eos);
    int unsigned gap;
    if (burst_left == 0) begin
      // one burst in four runs back to back with the previous one
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_has_byte      <= has;
    in_end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    predict_utf8_item(b, has, eos);
    burst_left--;
  endtask

  // String under construction; sent by send_string.
  logic [7:0] str_buf[$];

  // Appends one byte to the string under construction.
  task automatic add_byte(input logic [7:0] v);
    str_buf = {str_buf, v};
  endtask

  // Sends str_buf as one string. The end marker rides on the last byte, or
  // comes as a bare item when bare_end is set (always for an empty string).
  // idle_odds > 0 sprinkles idle items (has_byte = 0, no end) between bytes.
  task automatic send_string(input bit bare_end, input int unsigned idle_odds);
    int unsigned i;
    for (i = 0; i < str_buf.size(); i++) begin
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(str_buf[i], 1'b1, !bare_end && (i == str_buf.size() - 1));
    end
    if (bare_end || str_buf.size() == 0)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern cycles through four modes, picked by a count of clocks
  // ---------------------------------------------------------------------------
  int unsigned rx_cyc = 0;

  always @(posedge clk) begin
    rx_cyc++;
    case ((rx_cyc >> 7) & 3)
      0: out_ready <= 1'b1;                               // never stall
      1: out_ready <= ($urandom_range(0, 3) != 0);        // sparse random stalls
      2: out_ready <= ((rx_cyc % 8) < 5);                 // short periodic stalls
      default: out_ready <= ((rx_cyc % 32) >= 12);        // long periodic stalls
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: each verdict against the oldest pending string
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("is_valid: result with no string pending, actual %0b", out_is_valid);
        n_errors++;
      end else begin
        want = expected_verdicts.pop_front();
        n_checked++;
        if (out_is_valid !== want) begin
          $error("is_valid mismatch: expected %0b, actual %0b", want, out_is_valid);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty string, then ASCII extremes, overlong two-byte lead and a
  // four-byte sequence above U+10FFFF (both accepted by design).
  task automatic test_lead_classes();
    str_buf = {};
    send_string(1'b0, 0);
    str_buf = '{8'h00, 8'h7F, 8'hC0, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_string(1'b0, 0);
  endtask

  // Floors after E0 and F0, right at the edge on both sides; surrogate
  // range after ED goes through.
  task automatic test_first_byte_bounds();
    str_buf = '{8'hE0, 8'hA0, 8'hBF, 8'hED, 8'hA0, 8'h80};
    send_string(1'b0, 0);
    str_buf = '{8'hE0, 8'h9F};
    send_string(1'b0, 0);
    str_buf = '{8'hF0, 8'h90, 8'h80, 8'h80};
    send_string(1'b1, 0);
    str_buf = '{8'hF0, 8'h8F};
    send_string(1'b0, 0);
  endtask

  // Bad leads, bad continuation, cut-short tail, bytes after an error,
  // and an idle item in the middle of a sequence.
  task automatic test_malformed();
    str_buf = '{8'h80};
    send_string(1'b0, 0);
    str_buf = '{8'hF8};
    send_string(1'b0, 0);
    str_buf = '{8'hFF, 8'hC2};   // error, then a lead that must be ignored
    send_string(1'b0, 0);
    str_buf = '{8'hC3, 8'h41};
    send_string(1'b0, 0);
    send_item(8'hE2, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0); // idle: data must be ignored
    send_item(8'h82, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1); // end with one continuation still owed
  endtask

  task automatic gen_random_string();
    int unsigned kind;
    int unsigned n_chars;
    int unsigned i;
    logic [7:0]  lead;
    str_buf = {};
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // pure noise
      n_chars = $urandom_range(1, 6);
      for (i = 0; i < n_chars; i++) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    n_chars = $urandom_range(0, 6);
    for (i = 0; i < n_chars; i++) begin
      case ($urandom_range(0, 3))
        0: add_byte(8'($urandom_range(0, 127)));
        1: begin
          add_byte(8'($urandom_range(8'hC0, 8'hDF)));
          add_byte(8'h80 | 8'($urandom_range(0, 63)));
        end
        2: begin
          lead = ($urandom_range(0, 2) == 0) ? PAT_L3 : 8'($urandom_range(8'hE0, 8'hEF));
          add_byte(lead);
          // now and then skip the floor so that both sides of A0 show up
          if (lead == PAT_L3 && $urandom_range(0, 9) != 0)
            add_byte(8'($urandom_range(8'hA0, 8'hBF)));
          else
            add_byte(8'h80 | 8'($urandom_range(0, 63)));
          add_byte(8'h80 | 8'($urandom_range(0, 63)));
        end
        default: begin
          lead = ($urandom_range(0, 2) == 0) ? PAT_L4 : 8'($urandom_range(8'hF0, 8'hF7));
          add_byte(lead);
          if (lead == PAT_L4 && $urandom_range(0, 9) != 0)
            add_byte(8'($urandom_range(8'h90, 8'hBF)));
          else
            add_byte(8'h80 | 8'($urandom_range(0, 63)));
          add_byte(8'h80 | 8'($urandom_range(0, 63)));
          add_byte(8'h80 | 8'($urandom_range(0, 63)));
        end
      endcase
    end
    // about one string in five gets broken
    if (kind <= 2 && str_buf.size() != 0) begin
      case ($urandom_range(0, 2))
        0: str_buf[$urandom_range(0, str_buf.size() - 1)] = 8'($urandom_range(0, 255));
        1: void'(str_buf.pop_back());
        default: str_buf.insert($urandom_range(0, str_buf.size()), 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Mostly well-formed strings with random content, some broken, some noise.
  task automatic test_random_strings(input int unsigned n_items);
    int unsigned start_items;
    start_items = n_byte_items;
    while (n_byte_items - start_items < n_items) begin
      gen_random_string();
      send_string(($urandom_range(0, 1) == 1), 12);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_lead_classes();
    test_first_byte_bounds();
    test_malformed();
    test_random_strings(600);

    in_valid <= 1'b0;
    // drain; the hard stop above catches a verdict that never shows
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d strings (%0d valid, %0d invalid) from %0d byte/end items",
             n_strings, n_good, n_strings - n_good, n_byte_items);
    $display("plus %0d idle items; %0d verdicts compared, %0d errors",
             n_idle_items, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
